// File: hw/rtl/dps_pkg.sv
// Shared types and constants for the dynamic priority scheduler.
// Holds the queue entry layout, the token passed along the cell row and the codes.
// No dependencies.
`default_nettype none

package dps_pkg;

  localparam int unsigned MaxProcsDefault = 16;

  localparam int unsigned IdW      = 8;
  localparam int unsigned TimeW    = 8;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 3;

  localparam logic [CfgW-1:0]  BasePrioReset = 8'd100;
  localparam logic [CfgW-1:0]  PrioStepReset = 8'd12;
  localparam logic [PrioW-1:0] PrioMin       = 16'h8000;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_LOADED   = 3'd0,
    STAT_REJECTED = 3'd1,
    STAT_REQUEUED = 3'd2,
    STAT_FINISHED = 3'd3,
    STAT_IDLE     = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_PRIO = 1'b0,
    REG_PRIO_STEP = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_COMMIT
  } fsm_e;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic [TimeW-1:0]        need;
    logic [TimeW-1:0]        used;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   go;
    logic   found;
    entry_t ent;
  } token_t;

  typedef struct packed {
    logic load;
    logic remove;
    logic requeue;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/dps_cell.sv
// One slot of the ready queue: holds an entry, compares it against the passing
// best-so-far token and shifts towards the head on removal. Uses dps_pkg.
`default_nettype none

module dps_cell #(
  parameter int unsigned MAX_PROCS = dps_pkg::MaxProcsDefault,
  parameter int unsigned IDX       = 0,
  localparam int unsigned IdxW     = $clog2(MAX_PROCS),
  localparam int unsigned LenW     = $clog2(MAX_PROCS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LenW-1:0]     len_i,
  input  logic [IdxW-1:0]     best_i,
  input  dps_pkg::cell_ctrl_t ctrl_i,
  input  dps_pkg::entry_t     load_ent_i,
  input  dps_pkg::entry_t     upd_ent_i,
  input  dps_pkg::entry_t     next_ent_i,
  output dps_pkg::entry_t     ent_o,
  input  dps_pkg::token_t     tok_i,
  input  logic [IdxW-1:0]     tok_idx_i,
  output dps_pkg::token_t     tok_o,
  output logic [IdxW-1:0]     tok_idx_o
);
  import dps_pkg::*;

  localparam logic [LenW-1:0] MyPos = LenW'(IDX);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  entry_t          ent_q, ent_d;
  logic            go_q, go_d;
  logic            found_q, found_d;
  entry_t          tent_q, tent_d;
  logic [IdxW-1:0] tidx_q, tidx_d;
  logic            occupied;
  logic            take;
  logic [LenW-1:0] tail_pos;

  assign occupied = MyPos < len_i;
  assign tail_pos = len_i - LenW'(1);
  assign take     = tok_i.go && occupied &&
                    (!tok_i.found || ($signed(ent_q.prio) > $signed(tok_i.ent.prio)));

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.load && (MyPos == len_i)) begin
      ent_d = load_ent_i;
    end
    if (ctrl_i.remove && (MyIdx >= best_i)) begin
      if (MyPos < tail_pos) begin
        ent_d = next_ent_i;
      end else if ((MyPos == tail_pos) && ctrl_i.requeue) begin
        ent_d = upd_ent_i;
      end
    end
  end

  always_comb begin
    go_d    = tok_i.go;
    found_d = tok_i.found | take;
    tent_d  = take ? ent_q : tok_i.ent;
    tidx_d  = take ? MyIdx : tok_idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    found_q <= found_d;
    tent_q  <= tent_d;
    tidx_q  <= tidx_d;
  end

  assign ent_o     = ent_q;
  assign tok_o     = '{go: go_q, found: found_q, ent: tent_q};
  assign tok_idx_o = tidx_q;

endmodule

`default_nettype wire

// File: hw/rtl/dynamic_priority_scheduler.sv
// Timing: m_axis_tvalid rises once a load beat has passed the commit state, and once a tick
// beat's best-so-far token has walked the cell row and the commit state has followed.
// The input takes no new beat until the current one has committed; a held result
// beat holds the commit and with it the input.
// Reset clears queue length, state and the output valid flag and loads the
// configuration defaults; queue contents stay undefined, no clearing pass.
// Top level: control, configuration registers and a row of dps_cell; uses dps_pkg.
`default_nettype none

module dynamic_priority_scheduler #(
  parameter int unsigned MAX_PROCS = dps_pkg::MaxProcsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dps_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] process_id, [15:8] need
  input  logic [dps_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] cmd
  input  logic [dps_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] chosen_id, [15:8] used, [23:16] remaining_time,
  // [39:24] new_priority, [40] all_done, [47:41] zero
  output logic [dps_pkg::OutDataW-1:0]  m_axis_tdata,
  // [2:0] status
  output logic [dps_pkg::OutUserW-1:0]  m_axis_tuser
);
  import dps_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_PROCS);
  localparam int unsigned LenW = $clog2(MAX_PROCS + 1);

  fsm_e             state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  cmd_e             cmd_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] need_q;
  entry_t           ch_q;
  logic [IdxW-1:0]  best_q;
  logic [CfgW-1:0]  base_q, step_q;

  logic             out_valid_q;
  status_e          out_status_q, out_status_d;
  logic [IdW-1:0]   out_id_q, out_id_d;
  logic [TimeW-1:0] out_used_q, out_used_d;
  logic [TimeW-1:0] out_rem_q, out_rem_d;
  logic [PrioW-1:0] out_prio_q, out_prio_d;
  logic             out_done_q, out_done_d;
  logic             out_we;

  logic             accept;
  logic             out_free;
  logic             launch;
  cell_ctrl_t       ctrl;
  entry_t           load_ent, upd_ent;
  logic [PrioW-1:0] load_prio;
  logic [PrioW:0]   prio_diff;
  logic             reject;
  logic             finished;

  token_t           tok     [MAX_PROCS+1];
  logic [IdxW-1:0]  tok_idx [MAX_PROCS+1];
  entry_t           ent     [MAX_PROCS];
  entry_t           nxt     [MAX_PROCS];

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign launch        = accept && (cmd_e'(s_axis_tuser[0]) == CMD_TICK) && (len_q != '0);

  assign tok[0]     = '{go: launch, found: 1'b0, ent: '0};
  assign tok_idx[0] = '0;

  assign load_prio = {8'h00, base_q} - {8'h00, need_q};
  assign reject    = (len_q == LenW'(MAX_PROCS)) || (need_q == '0);
  assign load_ent  = '{id: id_q, need: need_q, used: '0, prio: load_prio};

  assign prio_diff = {ch_q.prio[PrioW-1], ch_q.prio} - {9'h000, step_q};
  always_comb begin
    upd_ent      = ch_q;
    upd_ent.used = ch_q.used + TimeW'(1);
    upd_ent.prio = (prio_diff[PrioW] != prio_diff[PrioW-1]) ? PrioMin
                                                            : prio_diff[PrioW-1:0];
  end
  assign finished = (upd_ent.used == ch_q.need);

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    if (i + 1 < MAX_PROCS) begin : g_mid
      assign nxt[i] = ent[i+1];
    end else begin : g_end
      assign nxt[i] = '0;
    end

    dps_cell #(
      .MAX_PROCS (MAX_PROCS),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .len_i      (len_q),
      .best_i     (best_q),
      .ctrl_i     (ctrl),
      .load_ent_i (load_ent),
      .upd_ent_i  (upd_ent),
      .next_ent_i (nxt[i]),
      .ent_o      (ent[i]),
      .tok_i      (tok[i]),
      .tok_idx_i  (tok_idx[i]),
      .tok_o      (tok[i+1]),
      .tok_idx_o  (tok_idx[i+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    ctrl         = '0;
    out_we       = 1'b0;
    out_status_d = STAT_IDLE;
    out_id_d     = '0;
    out_used_d   = '0;
    out_rem_d    = '0;
    out_prio_d   = '0;
    out_done_d   = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = launch ? FSM_SCAN : FSM_COMMIT;
        end
      end
      FSM_SCAN: begin
        if (tok[MAX_PROCS].go) begin
          state_d = FSM_COMMIT;
        end
      end
      FSM_COMMIT: begin
        if (out_free) begin
          out_we  = 1'b1;
          state_d = FSM_IDLE;
          unique case (cmd_q)
            CMD_LOAD: begin
              out_status_d = reject ? STAT_REJECTED : STAT_LOADED;
              out_id_d     = id_q;
              out_rem_d    = need_q;
              out_prio_d   = load_prio;
              if (!reject) begin
                ctrl.load = 1'b1;
                len_d     = len_q + LenW'(1);
              end
            end
            CMD_TICK: begin
              if (len_q == '0) begin
                out_status_d = STAT_IDLE;
                out_done_d   = 1'b1;
              end else begin
                ctrl.remove  = 1'b1;
                ctrl.requeue = !finished;
                len_d        = finished ? len_q - LenW'(1) : len_q;
                out_status_d = finished ? STAT_FINISHED : STAT_REQUEUED;
                out_id_d     = ch_q.id;
                out_used_d   = upd_ent.used;
                out_rem_d    = ch_q.need - upd_ent.used;
                out_prio_d   = upd_ent.prio;
                out_done_d   = (len_d == '0);
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= BasePrioReset;
      step_q      <= PrioStepReset;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_BASE_PRIO: base_q <= cfg_data_i;
          REG_PRIO_STEP: step_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(s_axis_tuser[0]);
      id_q   <= s_axis_tdata[7:0];
      need_q <= s_axis_tdata[15:8];
    end
    if ((state_q == FSM_SCAN) && tok[MAX_PROCS].go) begin
      ch_q   <= tok[MAX_PROCS].ent;
      best_q <= tok_idx[MAX_PROCS];
    end
    if (out_we) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_used_q   <= out_used_d;
      out_rem_q    <= out_rem_d;
      out_prio_q   <= out_prio_d;
      out_done_q   <= out_done_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'b0, out_done_q, out_prio_q, out_rem_q, out_used_q, out_id_q};

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_PROCS))
    else $error("queue length beyond capacity");

  a_scan_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_PROCS].go |-> (state_q == FSM_SCAN) && tok[MAX_PROCS].found)
    else $error("scan token left the row outside a scan or without a winner");

  a_load_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |=> len_q == $past(len_q) + LenW'(1))
    else $error("accepted load did not grow the queue");

  a_remove_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.remove && !ctrl.requeue) |=> len_q == $past(len_q) - LenW'(1))
    else $error("finished entry did not shrink the queue");

endmodule

`default_nettype wire

// File: verif/dynamic_priority_scheduler_checker.sv
// Checker for the dynamic priority scheduler: watches the config port and both stream channels,
// keeps its own ready queue and compares every result beat field by field.
// Depends on dps_pkg.
module dynamic_priority_scheduler_checker
  import dps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgW-1:0]       cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // [7:0] process_id, [15:8] need
  input  logic [InDataW-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic [InUserW-1:0]    s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] chosen_id, [15:8] used, [23:16] remaining_time,
  // [39:24] new_priority, [40] all_done, [47:41] zero
  input  logic [OutDataW-1:0]   m_axis_tdata,
  // [2:0] status
  input  logic [OutUserW-1:0]   m_axis_tuser,
  output int                    errors_o,
  output int                    outstanding_o,
  output int                    occupancy_o
);

  localparam int MaxProcs = MaxProcsDefault;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] used;
    logic [TimeW-1:0] rem;
    logic [PrioW-1:0] prio;
    logic             done;
  } sched_result_t;

  logic [IdW-1:0]   ready_id   [MaxProcs];
  logic [TimeW-1:0] ready_need [MaxProcs];
  logic [TimeW-1:0] ready_used [MaxProcs];
  int               ready_prio [MaxProcs];
  int               ready_len;
  logic [CfgW-1:0]  base_prio;
  logic [CfgW-1:0]  prio_step;
  sched_result_t    owed_results[$];
  int               errors = 0;

  assign errors_o      = errors;
  assign outstanding_o = owed_results.size();
  assign occupancy_o   = ready_len;

  function automatic sched_result_t schedule_beat(cmd_e cmd, logic [IdW-1:0] pid,
                                                  logic [TimeW-1:0] need);
    sched_result_t    r;
    int               best;
    int               p;
    logic [IdW-1:0]   e_id;
    logic [TimeW-1:0] e_need;
    logic [TimeW-1:0] e_used;
    r = '0;
    if (cmd == CMD_LOAD) begin
      p = int'(base_prio) - int'(need);
      r.status = (ready_len >= MaxProcs || need == 0) ? STAT_REJECTED : STAT_LOADED;
      r.id     = pid;
      r.rem    = need;
      r.prio   = p[PrioW-1:0];
      if (r.status == STAT_LOADED) begin
        ready_id[ready_len]   = pid;
        ready_need[ready_len] = need;
        ready_used[ready_len] = '0;
        ready_prio[ready_len] = p;
        ready_len++;
      end
    end else if (ready_len == 0) begin
      r.status = STAT_IDLE;
      r.done   = 1'b1;
    end else begin
      best = 0;
      for (int i = 1; i < ready_len; i++) begin
        if (ready_prio[i] > ready_prio[best]) best = i;
      end
      e_id   = ready_id[best];
      e_need = ready_need[best];
      e_used = ready_used[best] + 1'b1;
      p      = ready_prio[best] - int'(prio_step);
      if (p < -32768) p = -32768;
      for (int i = best; i < ready_len - 1; i++) begin
        ready_id[i]   = ready_id[i+1];
        ready_need[i] = ready_need[i+1];
        ready_used[i] = ready_used[i+1];
        ready_prio[i] = ready_prio[i+1];
      end
      ready_len--;
      if (e_used == e_need) begin
        r.status = STAT_FINISHED;
      end else begin
        r.status = STAT_REQUEUED;
        ready_id[ready_len]   = e_id;
        ready_need[ready_len] = e_need;
        ready_used[ready_len] = e_used;
        ready_prio[ready_len] = p;
        ready_len++;
      end
      r.id   = e_id;
      r.used = e_used;
      r.rem  = e_need - e_used;
      r.prio = p[PrioW-1:0];
      r.done = (ready_len == 0);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [PrioW-1:0] exp_v, logic [PrioW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      ready_len = 0;
      base_prio = BasePrioReset;
      prio_step = PrioStepReset;
      owed_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BASE_PRIO) base_prio = cfg_data_i;
        else                             prio_step = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result beat expected none actual %h/%h", $time,
                   m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", 16'(want.status), 16'(m_axis_tuser));
          check_field("chosen_id", 16'(want.id), 16'(m_axis_tdata[7:0]));
          check_field("used", 16'(want.used), 16'(m_axis_tdata[15:8]));
          check_field("remaining_time", 16'(want.rem), 16'(m_axis_tdata[23:16]));
          check_field("new_priority", want.prio, m_axis_tdata[39:24]);
          check_field("all_done", 16'(want.done), 16'(m_axis_tdata[40]));
          check_field("pad", 16'h0, 16'(m_axis_tdata[47:41]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(schedule_beat(cmd_e'(s_axis_tuser[0]), s_axis_tdata[7:0],
                                             s_axis_tdata[15:8]));
      end
    end
  end

endmodule

// File: verif/dynamic_priority_scheduler_tb.sv
// Testbench top for the dynamic priority scheduler: clock, reset, stimulus and verdict.
// Drives directed and random load/tick beats through several register settings;
// depends on dps_pkg, dynamic_priority_scheduler and dynamic_priority_scheduler_checker.
module dynamic_priority_scheduler_tb;
  import dps_pkg::*;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = MaxProcsDefault + 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  int                  errors;
  int                  outstanding;
  int                  occupancy;
  int                  beats_sent = 0;
  int                  send_idle = 25;
  int                  recv_idle = 58;
  int                  quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  dynamic_priority_scheduler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  dynamic_priority_scheduler_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .outstanding_o(outstanding), .occupancy_o(occupancy)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("dynamic_priority_scheduler_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(cmd_e cmd, logic [IdW-1:0] pid, logic [TimeW-1:0] need);
    if (beats_sent < 700) begin
      send_idle = 25;
      recv_idle = 58;
    end else if (beats_sent < 1400) begin
      send_idle = 58;
      recv_idle = 25;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {need, pid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [CfgW-1:0] base, logic [CfgW-1:0] step);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BASE_PRIO;
    cfg_data_i <= base;
    @(negedge clk_i);
    cfg_idx_i  <= REG_PRIO_STEP;
    cfg_data_i <= step;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_queue();
    while (occupancy != 0) begin
      send_beat(CMD_TICK, 8'($urandom), 8'($urandom));
    end
    settle();
  endtask

  task automatic random_beats(int count);
    int               tick_pct;
    int               roll;
    logic [TimeW-1:0] need;
    tick_pct = 55;
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: tick_pct = 35;
          1: tick_pct = 55;
          default: tick_pct = 80;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) need = '0;
      else if (roll < 8) need = 8'($urandom);
      else need = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 99) < tick_pct) send_beat(CMD_TICK, 8'($urandom), 8'($urandom));
      else send_beat(CMD_LOAD, 8'($urandom), need);
    end
  endtask

  initial begin
    logic [CfgW-1:0] bases [6];
    logic [CfgW-1:0] steps [6];
    bases = '{8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom), 8'd100};
    steps = '{8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom), 8'd12};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_regs(BasePrioReset, PrioStepReset);

    send_beat(CMD_TICK, 8'h00, 8'h00);
    send_beat(CMD_LOAD, 8'h00, 8'h00);
    send_beat(CMD_LOAD, 8'hFF, 8'hFF);
    send_beat(CMD_LOAD, 8'h5A, 8'h01);
    send_beat(CMD_LOAD, 8'hA5, 8'h01);
    send_beat(CMD_TICK, 8'hFF, 8'hFF);
    send_beat(CMD_TICK, 8'h00, 8'h00);
    send_beat(CMD_TICK, 8'h00, 8'h00);
    for (int i = 1; i < 16; i++) send_beat(CMD_LOAD, 8'(i), 8'd2);
    send_beat(CMD_LOAD, 8'h77, 8'h03);
    send_beat(CMD_TICK, 8'h00, 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_regs(bases[ph], steps[ph]);
      if (steps[ph] == 8'd255 && bases[ph] == 8'd255) begin
        // drive one entry down to the priority floor
        drain_queue();
        send_beat(CMD_LOAD, 8'hC3, 8'hFF);
        repeat (140) send_beat(CMD_TICK, 8'($urandom), 8'($urandom));
      end
      random_beats(200);
    end

    settle();
    if (errors == 0) begin
      $display("dynamic_priority_scheduler_tb: clean");
    end else begin
      $display("dynamic_priority_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
